[src/btr_pkg.sv]
// Package: shared constants, types and direction tables of the binary line tracer.
`timescale 1ns / 1ps
package btr_pkg;

   localparam int COORD_W = 6;
   localparam int POS_W   = 12;
   localparam int CNT_W   = 13;
   localparam int DIM_W   = 7;
   localparam int MINL_W  = 13;
   localparam int LNUM_W  = 12;
   localparam int MAX_DIM = 64;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_MINLEN = 2'd2;

   typedef struct packed {
      logic               op;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               pixel_on;
   } cmd_type;

   typedef struct packed {
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [MINL_W-1:0] min_length;
   } cfg_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_EMIT_RD, ST_EMIT_OUT, ST_SCAN_RD, ST_SCAN_CHK,
      ST_PROBE_RD, ST_PROBE_CHK, ST_JUDGE
   } state_type;

   function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
      logic signed [1:0] r;
      unique case (d)
         3'd0, 3'd6, 3'd7: r = -2'sd1;
         3'd1, 3'd5:       r = 2'sd0;
         default:          r = 2'sd1;
      endcase
      return r;
   endfunction

   function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
      logic signed [1:0] r;
      unique case (d)
         3'd0, 3'd1, 3'd2: r = -2'sd1;
         3'd3, 3'd7:       r = 2'sd0;
         default:          r = 2'sd1;
      endcase
      return r;
   endfunction

endpackage

[src/btr_front.sv]
// Front end: accepts command beats and holds them in a two-entry queue.
`timescale 1ns / 1ps
module btr_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  btr_pkg::cmd_type        cmd_in,
   input  btr_pkg::back_status_type status,
   output logic                    cmd_valid,
   output btr_pkg::cmd_type        cmd_out
);
   btr_pkg::cmd_type q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;

   assign busy      = (cnt_ff == 2'd2) || status.clearing;
   assign push      = start && !busy;
   assign pop       = status.pop && (cnt_ff != 2'd0);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_out   = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cmd_in;
      end
   end
endmodule

[src/btr_back.sv]
// Back end: image memory, line store and the scan, trace and emit sequencer.
`timescale 1ns / 1ps
module btr_back (
   input  logic                            clock,
   input  logic                            reset,
   input  btr_pkg::cfg_type                cfg,
   input  logic                            cmd_valid,
   input  btr_pkg::cmd_type                cmd,
   output btr_pkg::back_status_type        status,
   output logic                            rsp_valid,
   output logic [btr_pkg::COORD_W-1:0]     rsp_point_x,
   output logic [btr_pkg::COORD_W-1:0]     rsp_point_y,
   output logic [btr_pkg::LNUM_W-1:0]      rsp_line_number,
   output logic                            rsp_last_of_line,
   output logic                            rsp_image_done
);
   localparam int PW = btr_pkg::POS_W;
   localparam int CW = btr_pkg::CNT_W;
   localparam int DEPTH = 1 << PW;

   logic img_mem [DEPTH];
   logic [PW-1:0] ls_mem [DEPTH];

   btr_pkg::state_type state_ff, state_in;
   logic [CW-1:0] sp_ff, sp_in;          // scan position, may reach the end of the image
   logic [PW-1:0] tp_ff, tp_in;
   logic [PW-1:0] start_ff, start_in;
   logic [PW-1:0] nidx_ff, nidx_in;
   logic [2:0]    dir_ff, dir_in;
   logic [2:0]    n_ff, n_in;
   logic          pass_ff, pass_in;
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] emit_ff, emit_in;
   logic [btr_pkg::LNUM_W-1:0] lines_ff, lines_in;
   logic [PW-1:0] clr_ff, clr_in;

   logic          rv_ff, rv_in;
   logic [btr_pkg::COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [btr_pkg::LNUM_W-1:0]  ln_ff, ln_in;
   logic          last_ff, last_in, done_ff, done_in;

   logic          img_we, img_wd, img_rd_ff;
   logic [PW-1:0] img_wa, img_ra;
   logic          ls_we;
   logic [PW-1:0] ls_wa, ls_wd, ls_ra, ls_rd_ff;

   logic [btr_pkg::DIM_W-1:0] w, h;
   logic [btr_pkg::COORD_W-1:0] sx, tx, ty;
   logic [btr_pkg::DIM_W-1:0] sy;
   logic signed [7:0] nx, ny;
   logic in_bounds;
   logic [PW-1:0] nidx;
   logic [2:0] dir_next;
   logic [CW-1:0] emit_plus;

   assign w = (cfg.width > 7'(btr_pkg::MAX_DIM)) ? 7'(btr_pkg::MAX_DIM) : cfg.width;
   assign h = (cfg.height > 7'(btr_pkg::MAX_DIM)) ? 7'(btr_pkg::MAX_DIM) : cfg.height;
   assign sx = sp_ff[5:0];
   assign sy = sp_ff[12:6];
   assign tx = tp_ff[5:0];
   assign ty = tp_ff[11:6];
   assign nx = $signed({2'b00, tx}) + 8'(btr_pkg::dir_dx(dir_ff));
   assign ny = $signed({2'b00, ty}) + 8'(btr_pkg::dir_dy(dir_ff));
   assign in_bounds = (nx >= 0) && (ny >= 0) && (nx < $signed({1'b0, w}))
                      && (ny < $signed({1'b0, h}));
   assign nidx = {ny[5:0], nx[5:0]};
   assign dir_next = n_ff[0] ? dir_ff + n_ff : dir_ff - n_ff;
   assign emit_plus = emit_ff + 13'd1;

   always_comb begin
      state_in = state_ff;
      sp_in = sp_ff;     tp_in = tp_ff;       start_in = start_ff;
      nidx_in = nidx_ff; dir_in = dir_ff;     n_in = n_ff;
      pass_in = pass_ff; head_in = head_ff;   tail_in = tail_ff;
      count_in = count_ff; emit_in = emit_ff; lines_in = lines_ff;
      clr_in = clr_ff;
      rv_in = 1'b0; px_in = px_ff; py_in = py_ff; ln_in = ln_ff;
      last_in = last_ff; done_in = done_ff;
      img_we = 1'b0; img_wa = sp_ff[PW-1:0]; img_wd = 1'b0; img_ra = sp_ff[PW-1:0];
      ls_we = 1'b0; ls_wa = tail_ff; ls_wd = tp_ff; ls_ra = head_ff + emit_ff[PW-1:0];
      status.clearing = 1'b0;
      status.pop = 1'b0;

      unique case (state_ff)
         btr_pkg::ST_CLEAR: begin
            status.clearing = 1'b1;
            img_we = 1'b1;
            img_wa = clr_ff;
            clr_in = clr_ff + 12'd1;
            if (clr_ff == PW'(DEPTH - 1)) begin
               state_in = btr_pkg::ST_IDLE;
            end
         end
         btr_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               status.pop = 1'b1;
               head_in = '0; tail_in = '0; count_in = '0; emit_in = '0;
               if (cmd.op == btr_pkg::OP_WRITE) begin
                  img_we = 1'b1;
                  img_wa = {cmd.row, cmd.col};
                  img_wd = cmd.pixel_on;
                  sp_in = '0;
                  lines_in = '0;
               end else if (emit_ff < count_ff) begin
                  head_in = head_ff; tail_in = tail_ff;
                  count_in = count_ff; emit_in = emit_ff;
                  state_in = btr_pkg::ST_EMIT_RD;
               end else begin
                  state_in = btr_pkg::ST_SCAN_RD;
               end
            end
         end
         btr_pkg::ST_EMIT_RD: begin
            state_in = btr_pkg::ST_EMIT_OUT;
         end
         btr_pkg::ST_EMIT_OUT: begin
            rv_in = 1'b1;
            px_in = ls_rd_ff[5:0];
            py_in = ls_rd_ff[11:6];
            ln_in = lines_ff;
            last_in = (emit_plus == count_ff);
            done_in = 1'b0;
            emit_in = emit_plus;
            if (emit_plus == count_ff) begin
               lines_in = lines_ff + 12'd1;
               head_in = '0; tail_in = '0; count_in = '0; emit_in = '0;
            end
            state_in = btr_pkg::ST_IDLE;
         end
         btr_pkg::ST_SCAN_RD: begin
            if (sp_ff[CW-1] || (sy >= h)) begin
               // Image exhausted: report done with zero point fields.
               rv_in = 1'b1;
               px_in = '0; py_in = '0; ln_in = '0; last_in = 1'b0; done_in = 1'b1;
               head_in = '0; tail_in = '0; count_in = '0; emit_in = '0;
               state_in = btr_pkg::ST_IDLE;
            end else if ({1'b0, sx} >= w) begin
               sp_in = {sy[5:0] + 6'd1 == 6'd0, sy[5:0] + 6'd1, 6'd0};
            end else begin
               state_in = btr_pkg::ST_SCAN_CHK;
            end
         end
         btr_pkg::ST_SCAN_CHK: begin
            if (img_rd_ff) begin
               img_we = 1'b1;
               tp_in = sp_ff[PW-1:0];
               start_in = sp_ff[PW-1:0];
               ls_we = 1'b1;
               ls_wa = tail_ff;
               ls_wd = sp_ff[PW-1:0];
               tail_in = tail_ff + 12'd1;
               count_in = count_ff + 13'd1;
               dir_in = '0; n_in = 3'd1; pass_in = 1'b0;
               state_in = btr_pkg::ST_PROBE_RD;
            end else begin
               sp_in = sp_ff + 13'd1;
               state_in = btr_pkg::ST_SCAN_RD;
            end
         end
         btr_pkg::ST_PROBE_RD, btr_pkg::ST_PROBE_CHK: begin
            img_ra = nidx;
            if (state_ff == btr_pkg::ST_PROBE_RD && in_bounds) begin
               nidx_in = nidx;
               state_in = btr_pkg::ST_PROBE_CHK;
            end else if (state_ff == btr_pkg::ST_PROBE_CHK && img_rd_ff) begin
               img_we = 1'b1;
               img_wa = nidx_ff;
               tp_in = nidx_ff;
               n_in = 3'd1;
               if (count_ff[CW-1] == 1'b0) begin
                  ls_we = 1'b1;
                  ls_wd = nidx_ff;
                  count_in = count_ff + 13'd1;
                  if (pass_ff) begin
                     ls_wa = head_ff - 12'd1;
                     head_in = head_ff - 12'd1;
                  end else begin
                     ls_wa = tail_ff;
                     tail_in = tail_ff + 12'd1;
                  end
               end
               state_in = btr_pkg::ST_PROBE_RD;
            end else if (n_ff == 3'd7) begin
               if (!pass_ff) begin
                  pass_in = 1'b1;
                  tp_in = start_ff;
                  dir_in = '0;
                  n_in = 3'd1;
                  state_in = btr_pkg::ST_PROBE_RD;
               end else begin
                  state_in = btr_pkg::ST_JUDGE;
               end
            end else begin
               dir_in = dir_next;
               n_in = n_ff + 3'd1;
               state_in = btr_pkg::ST_PROBE_RD;
            end
         end
         btr_pkg::ST_JUDGE: begin
            if (count_ff > cfg.min_length) begin
               state_in = btr_pkg::ST_EMIT_RD;
            end else begin
               head_in = '0; tail_in = '0; count_in = '0; emit_in = '0;
               state_in = btr_pkg::ST_SCAN_RD;
            end
         end
         default: state_in = btr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btr_pkg::ST_CLEAR;
         clr_ff   <= '0;
         sp_ff    <= '0; tp_ff <= '0; start_ff <= '0;
         dir_ff   <= '0; n_ff <= 3'd1; pass_ff <= 1'b0;
         head_ff  <= '0; tail_ff <= '0; count_ff <= '0; emit_ff <= '0;
         lines_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         sp_ff    <= sp_in; tp_ff <= tp_in; start_ff <= start_in;
         dir_ff   <= dir_in; n_ff <= n_in; pass_ff <= pass_in;
         head_ff  <= head_in; tail_ff <= tail_in; count_ff <= count_in;
         emit_ff  <= emit_in;
         lines_ff <= lines_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      nidx_ff <= nidx_in;
      px_ff <= px_in; py_ff <= py_in; ln_ff <= ln_in;
      last_ff <= last_in; done_ff <= done_in;
   end

   always_ff @(posedge clock) begin
      if (img_we) begin
         img_mem[img_wa] <= img_wd;
      end
      img_rd_ff <= img_mem[img_ra];
   end

   always_ff @(posedge clock) begin
      if (ls_we) begin
         ls_mem[ls_wa] <= ls_wd;
      end
      ls_rd_ff <= ls_mem[ls_ra];
   end

   assign rsp_valid        = rv_ff;
   assign rsp_point_x      = px_ff;
   assign rsp_point_y      = py_ff;
   assign rsp_line_number  = ln_ff;
   assign rsp_last_of_line = last_ff;
   assign rsp_image_done   = done_ff;
endmodule

[src/binary_line_tracer_top.sv]
// Top level of the binary line tracer: configuration registers, front and back ends.
//
// A pixel write takes one beat and gives no result. A fetch gives one result beat, strobed by
// rsp_valid for one cycle; the receiver cannot stall it. A fetch of an already traced point
// reads the line store in EMIT_RD and outputs it in EMIT_OUT. Tracing a new line visits each
// scanned pixel in SCAN_RD and SCAN_CHK, each in-image neighbour probe in PROBE_RD and
// PROBE_CHK, and each probe outside the image in PROBE_RD alone. After reset the image memory
// is cleared in a pass over all 4096 addresses, during which busy is high.
`timescale 1ns / 1ps
module binary_line_tracer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_op,
   input  logic [btr_pkg::COORD_W-1:0]     req_row,
   input  logic [btr_pkg::COORD_W-1:0]     req_col,
   input  logic                            req_pixel_on,
   output logic                            rsp_valid,
   output logic [btr_pkg::COORD_W-1:0]     rsp_point_x,
   output logic [btr_pkg::COORD_W-1:0]     rsp_point_y,
   output logic [btr_pkg::LNUM_W-1:0]      rsp_line_number,
   output logic                            rsp_last_of_line,
   output logic                            rsp_image_done,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [btr_pkg::MINL_W-1:0]      csr_wdata
);
   btr_pkg::cfg_type cfg_ff, cfg_in;
   btr_pkg::cmd_type cmd_in, cmd_q;
   btr_pkg::back_status_type status;
   logic cmd_valid;

   assign cmd_in = '{op: req_op, row: req_row, col: req_col, pixel_on: req_pixel_on};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            btr_pkg::CSR_WIDTH:  cfg_in.width = csr_wdata[btr_pkg::DIM_W-1:0];
            btr_pkg::CSR_HEIGHT: cfg_in.height = csr_wdata[btr_pkg::DIM_W-1:0];
            btr_pkg::CSR_MINLEN: cfg_in.min_length = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{width: 7'd64, height: 7'd64, min_length: 13'd10};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   btr_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .cmd_in(cmd_in), .status(status), .cmd_valid(cmd_valid), .cmd_out(cmd_q)
   );

   btr_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .cmd_valid(cmd_valid), .cmd(cmd_q),
      .status(status), .rsp_valid(rsp_valid), .rsp_point_x(rsp_point_x),
      .rsp_point_y(rsp_point_y), .rsp_line_number(rsp_line_number),
      .rsp_last_of_line(rsp_last_of_line), .rsp_image_done(rsp_image_done)
   );
endmodule

[src/btr_checker.sv]
// Port checker for the binary line tracer, bound to the top level.
`timescale 1ns / 1ps
module btr_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic [5:0]  rsp_point_x,
   input logic [5:0]  rsp_point_y,
   input logic [11:0] rsp_line_number,
   input logic        rsp_last_of_line,
   input logic        rsp_image_done
);
   // The memory clearing pass holds off commands straight after reset.
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   // Result beats never come back to back.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result beats");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_image_done) |-> (rsp_point_x == 6'd0 && rsp_point_y == 6'd0
         && rsp_line_number == 12'd0 && !rsp_last_of_line))
      else $error("done beat carries a point");

   a_no_result_in_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat straight after reset");
endmodule

bind binary_line_tracer_top btr_checker u_btr_checker (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
   .rsp_line_number(rsp_line_number), .rsp_last_of_line(rsp_last_of_line),
   .rsp_image_done(rsp_image_done)
);
